FILE: design/lesp_pkg.sv
// Package for the line ending splitter.
// Holds beat types, ending and class codes, and small helper functions.
// No dependencies.
package lesp_pkg;

    // Field widths and character codes
    localparam int LENGTH_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Result queue size
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Line ending kinds
    localparam logic [1:0] END_NONE = 2'd0;
    localparam logic [1:0] END_CRLF = 2'd1;
    localparam logic [1:0] END_CR   = 2'd2;
    localparam logic [1:0] END_LF   = 2'd3;

    // File ending classes
    localparam logic [2:0] CLASS_NONE  = 3'd0;
    localparam logic [2:0] CLASS_DOS   = 3'd1;
    localparam logic [2:0] CLASS_MAC   = 3'd2;
    localparam logic [2:0] CLASS_UNIX  = 3'd3;
    localparam logic [2:0] CLASS_MIXED = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } lesp_in_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] line_length;
        logic [1:0]             line_ending;
        logic [COUNT_BITS-1:0]  line_index;
        logic [LENGTH_BITS-1:0] longest_line;
        logic [2:0]             ending_class;
        logic                   run_last;
        logic                   file_done;
    } lesp_out_t;

    // Up to two results from one accepted byte, first in order is r0
    typedef struct packed {
        logic      v0;
        logic      v1;
        lesp_out_t r0;
        lesp_out_t r1;
    } lesp_push_t;

    // Saturating increments
    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
        len_inc = (&v) ? v : v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
        cnt_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_max(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [LENGTH_BITS-1:0] b);
        len_max = (a > b) ? a : b;
    endfunction

    // Class after a line of the given ending kind
    function automatic logic [2:0] class_next(input logic [2:0] cls, input logic [1:0] kind);
        logic [2:0] want;
        want = CLASS_NONE;
        unique case (kind)
            END_CRLF: want = CLASS_DOS;
            END_CR:   want = CLASS_MAC;
            END_LF:   want = CLASS_UNIX;
            default:  want = CLASS_NONE;
        endcase
        if (want == CLASS_NONE) begin
            class_next = cls;
        end else if (cls == CLASS_NONE || cls == want) begin
            class_next = want;
        end else begin
            class_next = CLASS_MIXED;
        end
    endfunction

endpackage

FILE: design/lesp_core.sv
// Line splitting state and per-byte result logic.
// Depends on lesp_pkg.
module lesp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  lesp_pkg::lesp_in_t  in_beat,
    output lesp_pkg::lesp_push_t push
);

    logic                             cr_pending_reg, cr_pending_next;
    logic [lesp_pkg::LENGTH_BITS-1:0] cur_len_reg, cur_len_next;
    logic [lesp_pkg::COUNT_BITS-1:0]  lines_reg, lines_next;
    logic [lesp_pkg::LENGTH_BITS-1:0] longest_reg, longest_next;
    logic [2:0]                       class_reg, class_next;

    logic                             is_cr, is_lf, eof, consumed;
    logic                             a_valid, b_valid;
    logic [1:0]                       a_kind, b_kind;
    logic [lesp_pkg::LENGTH_BITS-1:0] a_len, b_len, a_longest, b_longest;
    logic [lesp_pkg::LENGTH_BITS-1:0] cur_a, longest_a;
    logic [lesp_pkg::COUNT_BITS-1:0]  lines_a;
    logic [2:0]                       a_class, b_class, class_a;
    lesp_pkg::lesp_out_t              res_a, res_b;

    assign is_cr = (in_beat.data_byte == lesp_pkg::BYTE_CR);
    assign is_lf = (in_beat.data_byte == lesp_pkg::BYTE_LF);
    assign eof   = in_beat.end_of_file;

    // First result: closes a pending CR, as CR LF or as lone CR
    always_comb begin
        a_valid   = cr_pending_reg;
        consumed  = cr_pending_reg && is_lf;
        a_kind    = is_lf ? lesp_pkg::END_CRLF : lesp_pkg::END_CR;
        a_len     = is_lf ? lesp_pkg::len_inc(cur_len_reg) : cur_len_reg;
        a_longest = lesp_pkg::len_max(longest_reg, a_len);
        a_class   = lesp_pkg::class_next(class_reg, a_kind);
        cur_a     = a_valid ? '0 : cur_len_reg;
        lines_a   = a_valid ? lesp_pkg::cnt_inc(lines_reg) : lines_reg;
        longest_a = a_valid ? a_longest : longest_reg;
        class_a   = a_valid ? a_class : class_reg;
    end

    // Second result: the byte itself, when not swallowed by CR LF
    always_comb begin
        b_len     = lesp_pkg::len_inc(cur_a);
        b_valid   = !consumed && (is_lf || eof);
        if (is_cr) begin
            b_kind = lesp_pkg::END_CR;
        end else if (is_lf) begin
            b_kind = lesp_pkg::END_LF;
        end else begin
            b_kind = lesp_pkg::END_NONE;
        end
        b_longest = lesp_pkg::len_max(longest_a, b_len);
        b_class   = lesp_pkg::class_next(class_a, b_kind);
    end

    // Result beats
    always_comb begin
        res_a.line_length  = a_len;
        res_a.line_ending  = a_kind;
        res_a.line_index   = lines_reg;
        res_a.longest_line = a_longest;
        res_a.ending_class = a_class;
        res_a.run_last     = !b_valid;
        res_a.file_done    = eof && !b_valid;

        res_b.line_length  = b_len;
        res_b.line_ending  = b_kind;
        res_b.line_index   = lines_a;
        res_b.longest_line = b_longest;
        res_b.ending_class = b_class;
        res_b.run_last     = 1'b1;
        res_b.file_done    = eof;

        push.v0 = in_fire && (a_valid || b_valid);
        push.v1 = in_fire && a_valid && b_valid;
        push.r0 = a_valid ? res_a : res_b;
        push.r1 = res_b;
    end

    // Next state; end of file returns everything to reset values
    always_comb begin
        if (eof) begin
            cr_pending_next = 1'b0;
            cur_len_next    = '0;
            lines_next      = '0;
            longest_next    = '0;
            class_next      = lesp_pkg::CLASS_NONE;
        end else begin
            cr_pending_next = !consumed && is_cr;
            cur_len_next    = (consumed || b_valid) ? '0 : b_len;
            lines_next      = b_valid ? lesp_pkg::cnt_inc(lines_a) : lines_a;
            longest_next    = b_valid ? b_longest : longest_a;
            class_next      = b_valid ? b_class : class_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_pending_reg <= 1'b0;
            cur_len_reg    <= '0;
            lines_reg      <= '0;
            longest_reg    <= '0;
            class_reg      <= lesp_pkg::CLASS_NONE;
        end else if (in_fire) begin
            cr_pending_reg <= cr_pending_next;
            cur_len_reg    <= cur_len_next;
            lines_reg      <= lines_next;
            longest_reg    <= longest_next;
            class_reg      <= class_next;
        end
    end

endmodule

FILE: design/lesp_queue.sv
// Result queue: takes up to two beats per cycle, hands out one.
// Depends on lesp_pkg.
module lesp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lesp_pkg::lesp_push_t push,
    output logic                 room2,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lesp_pkg::lesp_out_t  m_data
);

    lesp_pkg::lesp_out_t            mem [lesp_pkg::QUEUE_DEPTH];
    logic [lesp_pkg::QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lesp_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic [lesp_pkg::QCNT_BITS-1:0] n_push;
    logic                           pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign room2   = (count_reg <= lesp_pkg::QCNT_BITS'(lesp_pkg::QUEUE_DEPTH - 2));
    assign n_push  = lesp_pkg::QCNT_BITS'(push.v0) + lesp_pkg::QCNT_BITS'(push.v1);
    assign count_next = count_reg + n_push - lesp_pkg::QCNT_BITS'(pop);

    // Storage writes
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem[wr_ptr_reg + lesp_pkg::QPTR_BITS'(1)] <= push.r1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + lesp_pkg::QPTR_BITS'(n_push);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + lesp_pkg::QPTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/line_ending_splitter.sv
// Line ending splitter, top level.
// Depends on lesp_pkg, lesp_core and lesp_queue.
//
// Usage:
//   s_valid/s_ready/s_data carry one file byte per beat, with end_of_file
//   on the last byte. m_valid/m_ready/m_data carry one finished line per
//   beat: length, ending kind, index, longest length, file ending class,
//   run_last and file_done.
//   A byte is accepted in every cycle while s_ready is high. Its results
//   are written into a four-entry result queue at the accepting edge and
//   show on m_data behind any older beats, from the next cycle if empty.
//   A byte produces zero, one or two result beats. The queue drains one
//   beat per cycle while m_ready is high; s_ready is high while at least
//   two queue slots are free. With m_ready high and at most one result
//   per byte, one byte per cycle flows; two results add a queued beat.
//   A held m_ready stall fills the queue and then drops s_ready; nothing
//   is lost and m_data holds while m_valid waits.
//   Reset (aresetn low, synchronous) empties the queue and clears the line
//   state; the block is ready in the first cycle after reset.
module line_ending_splitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lesp_pkg::lesp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lesp_pkg::lesp_out_t m_data
);

    logic                 in_fire;
    lesp_pkg::lesp_push_t push;

    assign in_fire = s_valid && s_ready;

    lesp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_beat (s_data),
        .push    (push)
    );

    lesp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room2   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: design/lesp_checker.sv
// Port-level checks for the line ending splitter, bound to the top level.
// Depends on lesp_pkg and line_ending_splitter.
module lesp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input lesp_pkg::lesp_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input lesp_pkg::lesp_out_t m_data
);

    // A waiting input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while waiting");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Only the end of file flushes an unterminated line
    a_unterm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.line_ending == lesp_pkg::END_NONE |-> m_data.file_done)
        else $error("unterminated line before end of file");

    // Longest length covers this line
    a_longest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.line_length <= m_data.longest_line)
        else $error("line longer than longest_line");

    // A terminated line always leaves a class set
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.line_ending != lesp_pkg::END_NONE
            |-> m_data.ending_class != lesp_pkg::CLASS_NONE)
        else $error("terminated line with no ending class");

endmodule

bind line_ending_splitter lesp_checker u_lesp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
